>>> sv/emac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// shared constants, types and microcode for the energy accumulator
package emac_pkg;

  localparam int NUM_CHANNELS   = 6;
  localparam int TICK_PERIOD_MS = 10;
  localparam int SEC_PER_HOUR   = 3600;
  localparam int CURRENT_SCALE  = 10;

  localparam int CH_W     = 3;
  localparam int CUR_W    = 16;
  localparam int TICK_W   = 32;
  localparam int VOLT_W   = 8;
  localparam int CNT_CFG_W = 3;
  localparam int ACC_W    = 64;
  localparam int RATE_W   = CUR_W + VOLT_W;
  localparam int PROD_W   = RATE_W + TICK_W;
  localparam int ENERGY_W = 32;

  localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int N_W      = $clog2(NUM_CHANNELS + 1);

  localparam longint ENERGY_DIV = longint'(TICK_PERIOD_MS) * SEC_PER_HOUR * CURRENT_SCALE;
  localparam int REM_W      = $clog2(ENERGY_DIV);
  localparam int DIV_DIGIT_W = 8;
  localparam int DIV_STEPS  = ACC_W / DIV_DIGIT_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int DIV_Y_W    = REM_W + DIV_DIGIT_W;
  localparam int DIV_SHIFT  = DIV_Y_W + REM_W;
  localparam int DIV_RECIP_W = DIV_SHIFT - REM_W + 1;
  localparam int DIV_MUL_W  = DIV_Y_W + DIV_RECIP_W;
  localparam longint DIV_RECIP = ((longint'(1) << DIV_SHIFT) + ENERGY_DIV - 1) / ENERGY_DIV;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [PADDR_W-1:0] REG_CHANNELS_IN_USE = 3'd0;
  localparam logic [PADDR_W-1:0] REG_SUPPLY_VOLTAGE  = 3'd4;

  localparam logic [CNT_CFG_W-1:0] CHANNELS_RESET = 3'd1;
  localparam logic [VOLT_W-1:0]    VOLTAGE_RESET  = 8'd100;

  localparam logic REQ_SET_CURRENT = 1'b0;
  localparam logic REQ_UPDATE_ALL  = 1'b1;

  localparam int UPC_W = 3;

  typedef enum logic [2:0] {
    COND_NONE     = 3'd0,
    COND_ALWAYS   = 3'd1,
    COND_NO_START = 3'd2,
    COND_DIV_BUSY = 3'd3,
    COND_OUT_BUSY = 3'd4,
    COND_LAST     = 3'd5
  } cond_t;

  typedef struct packed {
    logic             in_rdy;
    logic             fetch;
    logic             mult;
    logic             credit;
    logic             div_step;
    logic             emit;
    logic             next_ch;
    cond_t            cond;
    logic [UPC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic start;
    logic div_busy;
    logic out_busy;
    logic last_ch;
  } ustat_t;

  typedef struct packed {
    logic [CNT_CFG_W-1:0] channels_in_use;
    logic [VOLT_W-1:0]    supply_voltage;
  } cfg_t;

  localparam logic [UPC_W-1:0] UA_WAIT   = 3'd0;
  localparam logic [UPC_W-1:0] UA_FETCH  = 3'd1;
  localparam logic [UPC_W-1:0] UA_MULT   = 3'd2;
  localparam logic [UPC_W-1:0] UA_CREDIT = 3'd3;
  localparam logic [UPC_W-1:0] UA_DIV    = 3'd4;
  localparam logic [UPC_W-1:0] UA_EMIT   = 3'd5;
  localparam logic [UPC_W-1:0] UA_CHECK  = 3'd6;
  localparam logic [UPC_W-1:0] UA_NEXT   = 3'd7;

  function automatic uword_t ucode_rom(input logic [UPC_W-1:0] addr);
    uword_t w;
    w = '0;
    w.cond = COND_NONE;
    unique case (addr)
      UA_WAIT: begin
        w.in_rdy = 1'b1;
        w.cond   = COND_NO_START;
        w.target = UA_WAIT;
      end
      UA_FETCH:  w.fetch  = 1'b1;
      UA_MULT:   w.mult   = 1'b1;
      UA_CREDIT: w.credit = 1'b1;
      UA_DIV: begin
        w.div_step = 1'b1;
        w.cond     = COND_DIV_BUSY;
        w.target   = UA_DIV;
      end
      UA_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = COND_OUT_BUSY;
        w.target = UA_EMIT;
      end
      UA_CHECK: begin
        w.cond   = COND_LAST;
        w.target = UA_WAIT;
      end
      UA_NEXT: begin
        w.next_ch = 1'b1;
        w.cond    = COND_ALWAYS;
        w.target  = UA_FETCH;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = UA_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

>>> sv/emac_if.sv
`timescale 1ns / 1ps
`default_nettype none
// item channel interfaces for requests and results
interface emac_in_if import emac_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [CH_W-1:0]   channel;
  logic [CUR_W-1:0]  current;
  logic [TICK_W-1:0] now_tick;

  modport source (output valid, req_type, channel, current, now_tick, input ready);
  modport sink   (input valid, req_type, channel, current, now_tick, output ready);
endinterface

interface emac_out_if import emac_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CH_W-1:0]     out_channel;
  logic [ENERGY_W-1:0] channel_energy;
  logic [CUR_W-1:0]    channel_current;
  logic [ENERGY_W-1:0] total_energy;
  logic                last;

  modport source (output valid, out_channel, channel_energy, channel_current,
                  total_energy, last, input ready);
  modport sink   (input valid, out_channel, channel_energy, channel_current,
                  total_energy, last, output ready);
endinterface
`default_nettype wire

>>> sv/multichannel_energy_accumulator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// top level of the multichannel energy accumulator
// each accepted item runs fetch, multiply, credit, the byte-serial divider (8 digits)
// and emit per credited channel; an update-all item makes one pass per channel in use.
// no new item is taken until the sequence is back in wait; emit stalls on out_ch.ready
// reset: synchronous active-low rst_n clears accumulators, tick stamps, currents,
// sets channels_in_use to 1 and supply_voltage to 100
module multichannel_energy_accumulator_core
  import emac_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  emac_in_if.sink                 in_ch,
  emac_out_if.source              out_ch,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  cfg_t   cfg;
  uword_t uword;
  ustat_t stat;

  emac_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  emac_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .uword (uword)
  );

  emac_datapath u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .uword  (uword),
    .stat   (stat),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

>>> sv/emac_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// apb configuration registers
module emac_cfg_regs
  import emac_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  cfg_t cfg_r, cfg_nxt;
  logic wr_en;
  logic [PADDR_W-1:0] reg_addr;

  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite;
  assign reg_addr = {paddr[PADDR_W-1:2], 2'b00};

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_addr)
        REG_CHANNELS_IN_USE: cfg_nxt.channels_in_use = pwdata[CNT_CFG_W-1:0];
        REG_SUPPLY_VOLTAGE:  cfg_nxt.supply_voltage  = pwdata[VOLT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_addr)
      REG_CHANNELS_IN_USE: prdata = PDATA_W'(cfg_r.channels_in_use);
      REG_SUPPLY_VOLTAGE:  prdata = PDATA_W'(cfg_r.supply_voltage);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.channels_in_use <= CHANNELS_RESET;
      cfg_r.supply_voltage  <= VOLTAGE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

>>> sv/emac_useq.sv
`timescale 1ns / 1ps
`default_nettype none
// microcode sequencer: step counter, control rom and conditional jumps
module emac_useq
  import emac_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire ustat_t stat,
  output uword_t      uword
);

  logic [UPC_W-1:0] upc_r, upc_nxt;
  logic             take;

  assign uword = ucode_rom(upc_r);

  always_comb begin
    case (uword.cond)
      COND_NONE:     take = 1'b0;
      COND_ALWAYS:   take = 1'b1;
      COND_NO_START: take = !stat.start;
      COND_DIV_BUSY: take = stat.div_busy;
      COND_OUT_BUSY: take = stat.out_busy;
      COND_LAST:     take = stat.last_ch;
      default:       take = 1'b1;
    endcase
    upc_nxt = take ? uword.target : upc_r + UPC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= UA_WAIT;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule
`default_nettype wire

>>> sv/emac_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// channel state, multipliers, accumulator, divider and result register
module emac_datapath
  import emac_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire cfg_t   cfg,
  input  wire uword_t uword,
  output ustat_t      stat,
  emac_in_if.sink     in_ch,
  emac_out_if.source  out_ch
);

  localparam logic [DIV_RECIP_W-1:0] DIV_M = DIV_RECIP_W'(DIV_RECIP);
  localparam logic [DIV_Y_W-1:0]     DIV_C = DIV_Y_W'(ENERGY_DIV);

  logic [ACC_W-1:0]  acc_r   [NUM_CHANNELS];
  logic [TICK_W-1:0] tick_r  [NUM_CHANNELS];
  logic [CUR_W-1:0]  held_r  [NUM_CHANNELS];

  logic                req_r;
  logic [CUR_W-1:0]    cur_r;
  logic [TICK_W-1:0]   now_r;
  logic [CH_IDX_W-1:0] idx_r;
  logic [RATE_W-1:0]   rate_r;
  logic [TICK_W-1:0]   dt_r;
  logic [PROD_W-1:0]   prod_r;
  logic [ACC_W-1:0]    dvd_r;
  logic [REM_W-1:0]    rem_r;
  logic [ENERGY_W-1:0] quot_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_DIGIT_W-1:0] qd_r;
  logic                div_ph_r;
  logic [ENERGY_W-1:0] total_r;

  logic                out_valid_r;
  logic [CH_W-1:0]     out_ch_r;
  logic [ENERGY_W-1:0] out_energy_r;
  logic [CUR_W-1:0]    out_cur_r;
  logic [ENERGY_W-1:0] out_total_r;
  logic                out_last_r;

  logic                fire, ch_ok, start, out_busy, load_out, last_ch;
  logic [N_W-1:0]      n_eff;
  logic [ACC_W-1:0]    acc_sum;
  logic [ENERGY_W-1:0] total_sum;
  logic [DIV_Y_W-1:0]  div_y, div_rem;
  logic [DIV_MUL_W-1:0] div_prod;

  assign n_eff = (32'(cfg.channels_in_use) > NUM_CHANNELS) ? N_W'(NUM_CHANNELS)
                                                           : N_W'(cfg.channels_in_use);
  assign in_ch.ready = uword.in_rdy;
  assign fire  = in_ch.valid && uword.in_rdy;
  assign ch_ok = 32'(in_ch.channel) < NUM_CHANNELS;
  assign start = fire && ((in_ch.req_type == REQ_UPDATE_ALL) ? (n_eff != '0) : ch_ok);

  assign last_ch  = (req_r == REQ_SET_CURRENT) || ((N_W'(idx_r) + N_W'(1)) == n_eff);
  assign out_busy = out_valid_r && !out_ch.ready;
  assign load_out = uword.emit && !out_busy;

  assign stat.start    = start;
  assign stat.div_busy = !(div_ph_r && (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)));
  assign stat.out_busy = out_busy;
  assign stat.last_ch  = last_ch;

  assign acc_sum   = acc_r[idx_r] + ACC_W'(prod_r);
  assign total_sum = total_r + quot_r;

  // each quotient byte takes a reciprocal estimate step, then a remainder step
  assign div_y    = {rem_r, dvd_r[ACC_W-1 -: DIV_DIGIT_W]};
  assign div_prod = DIV_MUL_W'(div_y) * DIV_MUL_W'(DIV_M);
  assign div_rem  = div_y - DIV_Y_W'(qd_r) * DIV_C;

  always_ff @(posedge clk) begin
    if (fire) begin
      req_r <= in_ch.req_type;
      cur_r <= in_ch.current;
      now_r <= in_ch.now_tick;
      idx_r <= (in_ch.req_type == REQ_UPDATE_ALL) ? '0 : CH_IDX_W'(in_ch.channel);
      total_r <= '0;
    end else begin
      if (uword.next_ch) idx_r <= idx_r + CH_IDX_W'(1);
      if (load_out) total_r <= total_sum;
    end
    if (uword.fetch) begin
      rate_r <= RATE_W'(held_r[idx_r]) * RATE_W'(cfg.supply_voltage);
      dt_r   <= now_r - tick_r[idx_r];
    end
    if (uword.mult) prod_r <= PROD_W'(rate_r) * PROD_W'(dt_r);
    if (uword.credit) begin
      dvd_r    <= acc_sum;
      rem_r    <= '0;
      cnt_r    <= '0;
      div_ph_r <= 1'b0;
    end else if (uword.div_step) begin
      if (!div_ph_r) begin
        qd_r     <= div_prod[DIV_SHIFT +: DIV_DIGIT_W];
        div_ph_r <= 1'b1;
      end else begin
        dvd_r    <= {dvd_r[ACC_W-DIV_DIGIT_W-1:0], {DIV_DIGIT_W{1'b0}}};
        rem_r    <= div_rem[REM_W-1:0];
        quot_r   <= {quot_r[ENERGY_W-DIV_DIGIT_W-1:0], qd_r};
        cnt_r    <= cnt_r + DIV_CNT_W'(1);
        div_ph_r <= 1'b0;
      end
    end
    if (load_out) begin
      out_ch_r     <= CH_W'(idx_r);
      out_energy_r <= quot_r;
      out_cur_r    <= held_r[idx_r];
      out_total_r  <= (last_ch && (req_r == REQ_UPDATE_ALL)) ? total_sum : '0;
      out_last_r   <= last_ch;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        acc_r[i]  <= '0;
        tick_r[i] <= '0;
        held_r[i] <= '0;
      end
    end else if (uword.credit) begin
      acc_r[idx_r]  <= acc_sum;
      tick_r[idx_r] <= now_r;
      if (req_r == REQ_SET_CURRENT) held_r[idx_r] <= cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.out_channel     = out_ch_r;
  assign out_ch.channel_energy  = out_energy_r;
  assign out_ch.channel_current = out_cur_r;
  assign out_ch.total_energy    = out_total_r;
  assign out_ch.last            = out_last_r;

endmodule
`default_nettype wire

>>> test/tb_multichannel_energy_accumulator_core.sv
`timescale 1ns / 1ps
// testbench for the energy accumulator: random requests, predicted energy readings, apb setup
module tb_multichannel_energy_accumulator_core;
  import emac_pkg::*;

  localparam int          SETTLE_CYCLES  = 80;
  localparam int          QUIET_LIMIT    = 2000;
  localparam int          RANDOM_PHASES  = 6;
  localparam int          PHASE_ITEMS    = 60;
  localparam bit [63:0]   ENERGY_DIVISOR = 64'(TICK_PERIOD_MS) * 64'(SEC_PER_HOUR) *
                                           64'(CURRENT_SCALE);

  typedef struct {
    bit              req_type;
    bit [CH_W-1:0]   channel;
    bit [CUR_W-1:0]  current;
    bit [TICK_W-1:0] now_tick;
  } request_t;

  typedef struct {
    logic [CH_W-1:0]     ch;
    logic [ENERGY_W-1:0] energy;
    logic [CUR_W-1:0]    amps;
    logic [ENERGY_W-1:0] total;
    logic                is_last;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;

  emac_in_if  in_ch();
  emac_out_if out_ch();

  multichannel_energy_accumulator_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // meter state mirror
  bit [ACC_W-1:0]     energy_acc [NUM_CHANNELS];
  bit [TICK_W-1:0]    tick_stamp [NUM_CHANNELS];
  bit [CUR_W-1:0]     held_amps  [NUM_CHANNELS];
  bit [CNT_CFG_W-1:0] meter_count = CHANNELS_RESET;
  bit [VOLT_W-1:0]    line_volts  = VOLTAGE_RESET;

  request_t request_queue[$];
  reading_t expected_readings[$];
  request_t next_req;
  bit       idle_on = 1'b1;
  bit       item_taken = 1'b0;
  int       send_gap = 0;
  int       hold_left = 0;
  int       quiet_cycles = 0;
  int       fail_count = 0;
  bit [TICK_W-1:0] tick_now = '0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int draw_wait();
    if (!idle_on || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  function automatic bit [ENERGY_W-1:0] credit_channel_energy(int unsigned ch,
                                                             bit [TICK_W-1:0] now);
    bit [TICK_W-1:0] dt;
    bit [ACC_W-1:0]  rate;
    dt = now - tick_stamp[ch];
    rate = 64'(held_amps[ch]) * 64'(line_volts);
    energy_acc[ch] = energy_acc[ch] + rate * 64'(dt);
    tick_stamp[ch] = now;
    return 32'(energy_acc[ch] / ENERGY_DIVISOR);
  endfunction

  function automatic void predict_energy_readings(request_t r);
    reading_t             rd;
    int unsigned          n;
    bit [ENERGY_W-1:0]    e;
    bit [ENERGY_W-1:0]    total;
    if (r.req_type == REQ_SET_CURRENT) begin
      if (r.channel >= NUM_CHANNELS) return;
      e = credit_channel_energy(r.channel, r.now_tick);
      held_amps[r.channel] = r.current;
      rd = '{r.channel, e, r.current, '0, 1'b1};
      expected_readings.push_back(rd);
    end else begin
      n = (meter_count > NUM_CHANNELS) ? NUM_CHANNELS : meter_count;
      total = '0;
      for (int unsigned i = 0; i < n; i++) begin
        e = credit_channel_energy(i, r.now_tick);
        total += e;
        rd = '{CH_W'(i), e, held_amps[i], (i + 1 == n) ? total : '0, i + 1 == n};
        expected_readings.push_back(rd);
      end
    end
  endfunction

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || item_taken) begin
      item_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (request_queue.size() > 0) begin
        next_req = request_queue.pop_front();
        in_ch.req_type <= next_req.req_type;
        in_ch.channel  <= next_req.channel;
        in_ch.current  <= next_req.current;
        in_ch.now_tick <= next_req.now_tick;
        in_ch.valid    <= 1'b1;
        send_gap = draw_wait();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    request_t r;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      r = '{in_ch.req_type, in_ch.channel, in_ch.current, in_ch.now_tick};
      predict_energy_readings(r);
      item_taken = 1'b1;
    end
  end

  // result monitor
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    reading_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.out_channel, out_ch.channel_energy, out_ch.channel_current,
              out_ch.total_energy, out_ch.last};
      if (expected_readings.size() == 0) begin
        $display("%0t unexpected item: ch=%0d energy=%0d current=%0d total=%0d last=%0b",
                 $time, got.ch, got.energy, got.amps, got.total, got.is_last);
        fail_count++;
      end else begin
        want = expected_readings.pop_front();
        if (got.ch !== want.ch || got.energy !== want.energy || got.amps !== want.amps ||
            got.total !== want.total || got.is_last !== want.is_last) begin
          $display("%0t mismatch: expected ch=%0d energy=%0d current=%0d total=%0d last=%0b",
                   $time, want.ch, want.energy, want.amps, want.total, want.is_last);
          $display("%0t            actual ch=%0d energy=%0d current=%0d total=%0d last=%0b",
                   $time, got.ch, got.energy, got.amps, got.total, got.is_last);
          fail_count++;
        end
      end
      hold_left = draw_wait();
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic program_register(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    logic [PDATA_W-1:0] readback;
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == REG_CHANNELS_IN_USE) begin
      meter_count = data[CNT_CFG_W-1:0];
      readback = PDATA_W'(meter_count);
    end else begin
      line_volts = data[VOLT_W-1:0];
      readback = PDATA_W'(line_volts);
    end
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= addr;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== readback) begin
      $display("%0t register %0d readback: expected %0h actual %0h",
               $time, addr, readback, prdata);
      fail_count++;
    end
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  task automatic set_meter(input int unsigned count, input int unsigned volts);
    program_register(REG_CHANNELS_IN_USE, ($urandom & ~32'h7) | PDATA_W'(count));
    program_register(REG_SUPPLY_VOLTAGE, ($urandom & ~32'hFF) | PDATA_W'(volts));
  endtask

  task automatic push_request(input bit kind, input bit [CH_W-1:0] ch,
                              input bit [CUR_W-1:0] cur, input bit [TICK_W-1:0] tick);
    request_t r;
    r = '{kind, ch, cur, tick};
    request_queue.push_back(r);
  endtask

  task automatic wait_until_drained();
    do @(posedge clk);
    while (request_queue.size() != 0 || in_ch.valid || expected_readings.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_random_items(input int count);
    bit              kind;
    bit [CH_W-1:0]   ch;
    bit [CUR_W-1:0]  cur;
    for (int k = 0; k < count; k++) begin
      kind = ($urandom_range(0, 3) == 0) ? REQ_UPDATE_ALL : REQ_SET_CURRENT;
      if (kind == REQ_UPDATE_ALL) ch = CH_W'($urandom_range(0, 7));
      else if ($urandom_range(0, 9) == 0) ch = CH_W'($urandom_range(6, 7));
      else ch = CH_W'($urandom_range(0, 5));
      case ($urandom_range(0, 5))
        0:       cur = '0;
        1:       cur = '1;
        default: cur = CUR_W'($urandom);
      endcase
      case ($urandom_range(0, 9))
        0:       tick_now = $urandom;
        1:       ;
        default: tick_now = tick_now + $urandom_range(1, 100000);
      endcase
      push_request(kind, ch, cur, tick_now);
    end
  endtask

  initial begin
    int unsigned count, volts;
    in_ch.valid = 1'b0;
    in_ch.req_type = 1'b0;
    in_ch.channel = '0;
    in_ch.current = '0;
    in_ch.now_tick = '0;
    out_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: one channel, 100 V
    push_request(REQ_UPDATE_ALL, 3'd0, 16'h0000, 32'h0000_0000);
    push_request(REQ_SET_CURRENT, 3'd0, 16'hFFFF, 32'd1000);
    push_request(REQ_SET_CURRENT, 3'd5, 16'h0001, 32'hFFFF_FFFF);
    push_request(REQ_SET_CURRENT, 3'd6, 16'h1234, 32'd50);
    push_request(REQ_SET_CURRENT, 3'd7, 16'hFFFF, 32'hFFFF_FFFF);
    push_request(REQ_UPDATE_ALL, 3'd7, 16'hFFFF, 32'd5);
    wait_until_drained();

    // all channels at full current and voltage, energy past 32 bits
    set_meter(6, 255);
    for (int c = 0; c < NUM_CHANNELS; c++)
      push_request(REQ_SET_CURRENT, CH_W'(c), 16'hFFFF, TICK_W'(100 + c));
    push_request(REQ_UPDATE_ALL, 3'd0, 16'h0000, 32'hFFFF_FFFF);
    push_request(REQ_SET_CURRENT, 3'd2, 16'h0000, 32'h0000_0010);
    wait_until_drained();

    // zero channels in use
    set_meter(0, 1);
    push_request(REQ_UPDATE_ALL, 3'd3, 16'hAAAA, 32'h8000_0000);
    push_request(REQ_SET_CURRENT, 3'd4, 16'h8000, 32'h8000_0001);
    wait_until_drained();

    // channel count above capacity, zero volts
    set_meter(7, 0);
    push_request(REQ_UPDATE_ALL, 3'd5, 16'h5555, 32'hC000_0000);
    push_request(REQ_SET_CURRENT, 3'd1, 16'h5555, 32'h0000_0000);
    push_request(REQ_UPDATE_ALL, 3'd0, 16'h0000, 32'h0000_0100);
    wait_until_drained();

    tick_now = 32'h0000_0100;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      idle_on = (p != 2);
      case ($urandom_range(0, 9))
        0:       count = 0;
        1:       count = 7;
        default: count = $urandom_range(1, 6);
      endcase
      if (p == 0) count = 6;
      volts = (p == 1) ? 255 : (p == 3) ? 0 : $urandom_range(0, 255);
      set_meter(count, volts);
      queue_random_items(PHASE_ITEMS);
      wait_until_drained();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
